// ----- hdl/vtsi_pkg.sv -----
// ----------------------------------------------------------------------------
// vtsi_pkg
// Shared widths, beat payload types and constants of the velocity sync unit.
// ----------------------------------------------------------------------------
package vtsi_pkg;
  localparam int TimeW = 48;
  localparam int VelW = 32;
  localparam int GapW = 32;
  localparam int Axes = 6;
  localparam int DefaultFifoDepth = 16;
  localparam logic [GapW-1:0] MaxGapReset = 32'd200000;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_SYNC = 1'b1
  } op_t;

  typedef logic signed [VelW-1:0] vel_t;

  typedef struct packed {
    op_t             op;
    logic [TimeW-1:0] sample_time;
    logic [TimeW-1:0] request_time;
    vel_t            lin_x;
    vel_t            lin_y;
    vel_t            lin_z;
    vel_t            ang_x;
    vel_t            ang_y;
    vel_t            ang_z;
  } in_beat_t;

  typedef struct packed {
    logic            ok;
    logic [TimeW-1:0] out_time;
    vel_t            out_lin_x;
    vel_t            out_lin_y;
    vel_t            out_lin_z;
    vel_t            out_ang_x;
    vel_t            out_ang_y;
    vel_t            out_ang_z;
  } out_beat_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ----- hdl/vtsi_if.sv -----
// ----------------------------------------------------------------------------
// vtsi_in_if / vtsi_out_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface vtsi_in_if;
  import vtsi_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vtsi_out_if;
  import vtsi_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/vtsi_div.sv -----
// ----------------------------------------------------------------------------
// vtsi_div
// Restoring divider: one quotient bit per cycle, magnitude numerator over a
// 49-bit magnitude divisor, giving the quotient and the final remainder.
// ----------------------------------------------------------------------------
module vtsi_div #(
  parameter int NumW = 82,
  parameter int DenW = 49
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo,
  output logic [DenW:0]   rem
);
  localparam int CntW = $clog2(NumW + 1);
  logic [CntW-1:0] cnt;
  logic [NumW-1:0] shreg;
  logic [DenW-1:0] dreg;
  logic            busy;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem[DenW-1:0], shreg[NumW-1]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntW'(NumW);
      shreg <= num;
      dreg <= den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      shreg <= {shreg[NumW-2:0], 1'b0};
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- hdl/velocity_time_sync_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// velocity_time_sync_interpolator_unit
// Timestamped velocity sample queue with linear interpolation at sync times.
//
//   channel  dir  beat        handshake
//   in       in   in_beat_t   valid/ready
//   res      out  out_beat_t  valid/ready
//   cfg      in   max_gap     cfg_we/cfg_data
//
// A push takes the accept and one velocity write per axis. A sync takes the
// accept and a queue check (S_RDT0, S_RDT1, S_CHK), repeated as samples are
// dropped, then per axis the velocity reads, S_MUL0 to S_MUL1H on a shared
// 32 x 26 multiplier, a start of the 82-step divider, a wait on it and a
// store. Reset clears the queue pointers and sets max_gap to MaxGapReset. The
// input is not ready while an item is in work or a beat waits.
// ----------------------------------------------------------------------------
module velocity_time_sync_interpolator_unit #(
  parameter int FIFO_DEPTH = vtsi_pkg::DefaultFifoDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  vtsi_in_if.sink                 in,
  vtsi_out_if.source              res,
  input  logic                    cfg_we,
  input  logic [vtsi_pkg::GapW-1:0] cfg_data
);
  import vtsi_pkg::*;

  localparam int IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam int MemD = FIFO_DEPTH * Axes;
  localparam int MemAW = $clog2(MemD);
  localparam int NumW = 82;
  localparam int DenW = 49;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_RDT0, S_RDT1, S_CHK, S_RDV0, S_RDV1, S_MUL0, S_MUL0H,
    S_MUL1, S_MUL1H, S_DIV, S_DWAIT, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [GapW-1:0] max_gap;
  logic [TimeW-1:0] time_mem [FIFO_DEPTH];
  logic [VelW-1:0]  vel_mem [MemD];
  logic [IdxW-1:0] head;
  logic [CntW-1:0] count;
  in_beat_t beat;
  logic [IdxW-1:0] slot;
  logic [TimeW-1:0] t_rd, t0, t1;
  logic [VelW-1:0]  v_rd, v0;
  logic [2:0] axis;
  logic       pruned;
  logic signed [50:0] da, db, dd;
  logic signed [81:0] acc, prod;
  logic signed [VelW-1:0] mul_v;
  logic signed [49:0] t_sel;
  logic signed [25:0] mul_t;
  logic signed [57:0] mul_p;
  logic       half;
  logic [VelW-1:0] lanes [Axes];
  logic [IdxW-1:0] head_p1;
  logic [IdxW-1:0] t_addr;
  logic [MemAW-1:0] v_addr;
  logic [MemAW-1:0] w_addr;
  logic [VelW-1:0]  push_word;
  logic [CntW:0]    wr_sum;
  logic [IdxW-1:0]  wr_slot;
  logic div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [DenW:0]   div_rem;
  logic neg_q;
  logic [NumW:0] q_rnd;
  logic [VelW-1:0] sat;
  div_ctl_t dctl;

  assign head_p1 = (head == IdxW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  assign in.ready = (state == S_IDLE);
  assign dctl = '{start: div_start, busy: (state == S_DWAIT), done: div_done};

  always_ff @(posedge clk) begin
    t_rd <= time_mem[t_addr];
    v_rd <= vel_mem[v_addr];
    if (state == S_PUSH) begin
      time_mem[slot] <= beat.sample_time;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      vel_mem[w_addr] <= push_word;
    end
  end

  always_comb begin
    wr_sum = (CntW+1)'(head) + (CntW+1)'(count);
    if (wr_sum >= (CntW+1)'(FIFO_DEPTH)) begin
      wr_slot = IdxW'(wr_sum - (CntW+1)'(FIFO_DEPTH));
    end else begin
      wr_slot = IdxW'(wr_sum);
    end
    w_addr = MemAW'(slot) * MemAW'(Axes) + MemAW'(axis);
    case (axis)
      3'd0: push_word = beat.lin_x;
      3'd1: push_word = beat.lin_y;
      3'd2: push_word = beat.lin_z;
      3'd3: push_word = beat.ang_x;
      3'd4: push_word = beat.ang_y;
      default: push_word = beat.ang_z;
    endcase
    t_addr = (state == S_RDT1 || state == S_CHK) ? head_p1 : head;
    if (state inside {S_RDV1, S_MUL0, S_MUL0H, S_MUL1}) begin
      v_addr = MemAW'(head_p1) * MemAW'(Axes) + MemAW'(axis);
    end else begin
      v_addr = MemAW'(head) * MemAW'(Axes) + MemAW'(axis);
    end
    half = (state inside {S_MUL0H, S_MUL1H});
    mul_v = (state inside {S_MUL0, S_MUL0H}) ? signed'(v0) : signed'(v_rd);
    t_sel = (state inside {S_MUL0, S_MUL0H}) ? da[49:0] : db[49:0];
    mul_t = half ? {t_sel[49], t_sel[49:25]} : {1'b0, t_sel[24:0]};
    mul_p = mul_v * mul_t;
    prod = half ? (82'(mul_p) <<< 25) : 82'(mul_p);
    div_num = acc[81] ? NumW'(-acc) : NumW'(acc);
    neg_q = acc[81] ^ dd[50];
    q_rnd = {1'b0, div_quo} + ((({div_rem, 1'b0}) >= {2'b0, dd[50] ? 49'(-dd) : dd[48:0]})
            ? (NumW+1)'(1) : '0);
    if (neg_q) begin
      sat = (q_rnd > (NumW+1)'(33'h80000000)) ? 32'h80000000 : 32'(-q_rnd[31:0]);
    end else begin
      sat = (q_rnd > (NumW+1)'(32'h7fffffff)) ? 32'h7fffffff : q_rnd[31:0];
    end
  end

  vtsi_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dd[50] ? DenW'(-dd) : DenW'(dd)),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
      max_gap <= MaxGapReset;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            beat <= in.data;
            if (in.data.op == OP_PUSH) begin
              if (count >= CntW'(FIFO_DEPTH)) begin
                slot <= head;
                head <= head_p1;
              end else begin
                slot <= wr_slot;
                count <= count + 1'b1;
              end
              axis <= '0;
              state <= S_PUSH;
            end else begin
              pruned <= 1'b0;
              state <= S_RDT0;
            end
          end
        end
        S_PUSH: begin
          if (axis == 3'(Axes - 1)) begin
            state <= S_IDLE;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_RDT0: state <= S_RDT1;
        S_RDT1: begin
          t0 <= t_rd;
          state <= S_CHK;
        end
        S_CHK: begin
          t1 <= t_rd;
          res.data <= '0;
          if (count < CntW'(2)) begin
            state <= S_OUT;
            res.valid <= 1'b1;
          end else if (pruned) begin
            da <= 51'(t_rd) - 51'(beat.request_time);
            db <= 51'(beat.request_time) - 51'(t0);
            dd <= 51'(t_rd) - 51'(t0);
            axis <= '0;
            acc <= '0;
            state <= S_RDV0;
          end else if (t0 > beat.request_time) begin
            state <= S_OUT;
            res.valid <= 1'b1;
          end else if (t_rd < beat.request_time) begin
            head <= head_p1;
            count <= count - 1'b1;
            state <= S_RDT0;
          end else begin
            if ((beat.request_time - t0 > TimeW'(max_gap)) ||
                (t_rd - beat.request_time > TimeW'(max_gap))) begin
              head <= head_p1;
              count <= count - 1'b1;
            end
            pruned <= 1'b1;
            state <= S_RDT0;
          end
        end
        S_RDV0: state <= S_RDV1;
        S_RDV1: begin
          v0 <= v_rd;
          state <= S_MUL0;
        end
        S_MUL0: begin
          acc <= prod;
          state <= S_MUL0H;
        end
        S_MUL0H: begin
          acc <= acc + prod;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc <= acc + prod;
          state <= S_MUL1H;
        end
        S_MUL1H: begin
          acc <= acc + prod;
          if (dd == '0) begin
            lanes[axis] <= v0;
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_start <= 1'b1;
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            lanes[axis] <= sat;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (axis == 3'(Axes - 1)) begin
            res.data.ok <= 1'b1;
            res.data.out_time <= beat.request_time;
            res.data.out_lin_x <= lanes[0];
            res.data.out_lin_y <= lanes[1];
            res.data.out_lin_z <= lanes[2];
            res.data.out_ang_x <= lanes[3];
            res.data.out_ang_y <= lanes[4];
            res.data.out_ang_z <= lanes[5];
            res.valid <= 1'b1;
            state <= S_OUT;
          end else begin
            axis <= axis + 1'b1;
            acc <= '0;
            state <= S_RDV0;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FIFO_DEPTH)) else $error("queue fill beyond depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !in.ready) else $error("input taken while result waits");
  a_div_once: assert property (@(posedge clk) disable iff (rst)
    dctl.start |=> dctl.busy) else $error("divider started outside its wait state");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.data.ok) |-> (res.data.out_time == '0))
    else $error("failed sync carries a time");
endmodule
